/* hw/rtl/pfm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_pkg: shared types and constants of the page frame manager
// Frame count, field widths, request modes and result status codes.
// ----------------------------------------------------------------------------
package pfm_pkg;
	localparam int Frames = 16;
	localparam int FrW = $clog2(Frames);
	localparam int CntW = $clog2(Frames + 1);
	localparam int PageW = 31;
	localparam int PinW = 8;
	localparam int OutFrW = 4;

	typedef enum logic [1:0] {
		MODE_FETCH = 2'd0,
		MODE_UNPIN = 2'd1,
		MODE_NEW   = 2'd2,
		MODE_FLUSH = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_LOADED   = 3'd1,
		ST_CREATED  = 3'd2,
		ST_NO_FRAME = 3'd3,
		ST_UNPINNED = 3'd4,
		ST_NOT_RES  = 3'd5,
		ST_FLUSHED  = 3'd6,
		ST_NOTHING  = 3'd7
	} status_t;

	typedef struct packed {
		mode_t            mode;
		logic [PageW-1:0] page_id;
		logic             mark_dirty;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [OutFrW-1:0] frame;
		logic             writeback_needed;
		logic [PageW-1:0] write_page;
		logic             read_needed;
		logic             last;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DECIDE,
		BK_EMIT,
		BK_FLUSH
	} bk_state_t;
endpackage
`default_nettype wire

/* hw/rtl/pfm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_front: request intake
// Registers incoming words into a two-entry queue feeding the back end.
// ----------------------------------------------------------------------------
module pfm_front import pfm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  req_t      in_req,
	output logic      q_valid,
	input  wire logic q_take,
	output req_t      q_req
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_take;
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/pfm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_back: frame table and request execution
// Scans frames one per cycle for the page match and the LRU victim, then
// updates the table and emits results through an output register.
// ----------------------------------------------------------------------------
module pfm_back import pfm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_take,
	input  req_t      q_req,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);
	logic [PageW-1:0] page_q [Frames];
	logic [PinW-1:0]  pin_q  [Frames];
	logic             dirty_q [Frames];
	logic [FrW-1:0]   rank_q [Frames];
	logic [CntW-1:0]  used_q;

	bk_state_t st_q, st_d;
	req_t      req_q;
	logic [CntW-1:0] idx_q;
	logic            hit_q, vic_q;
	logic [FrW-1:0]  hit_f_q, vic_f_q;
	logic            any_q;
	res_t            res_q;
	res_t            res_d;
	logic            ov_q;

	logic [FrW-1:0]  i;
	logic            slot_free;
	logic            go_scan, scan_done, emit_ok;
	logic            fl_step, fl_word, fl_none, more_dirty;

	assign i = idx_q[FrW-1:0];
	assign slot_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_res = res_q;
	assign scan_done = (idx_q == CntW'(Frames - 1)) || (idx_q + 1'b1 >= used_q);

	// flush: one step per used frame, a word per dirty frame, or one "nothing" word
	assign fl_step = (st_q == BK_FLUSH) && slot_free;
	assign fl_word = fl_step && used_q != '0 && dirty_q[i];
	assign fl_none = fl_step && !fl_word && (used_q == '0 || scan_done) && !any_q;

	// a dirty used frame still ahead of the scan index
	always_comb begin
		more_dirty = 1'b0;
		for (int k = 0; k < Frames; k++)
			if (CntW'(k) > idx_q && CntW'(k) < used_q && dirty_q[k]) more_dirty = 1'b1;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (q_valid) st_d = (q_req.mode == MODE_FLUSH) ? BK_FLUSH : BK_SCAN;
			BK_SCAN: if (used_q == '0 || scan_done) st_d = BK_DECIDE;
			BK_DECIDE: st_d = BK_EMIT;
			BK_EMIT: if (slot_free) st_d = BK_IDLE;
			BK_FLUSH: if (slot_free && (used_q == '0 || scan_done)) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_take = (st_q == BK_IDLE) && q_valid;
		go_scan = (st_q == BK_SCAN) && used_q != '0;
		emit_ok = (st_q == BK_EMIT) && slot_free;
	end

	// next result word
	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		if (st_q == BK_FLUSH) begin
			if (fl_word) begin
				res_d.status = ST_FLUSHED;
				res_d.frame = OutFrW'(i);
				res_d.writeback_needed = 1'b1;
				res_d.write_page = page_q[i];
				res_d.last = !more_dirty;
			end else begin
				res_d.status = ST_NOTHING;
			end
		end else if (req_q.mode == MODE_UNPIN) begin
			res_d.status = hit_q ? ST_UNPINNED : ST_NOT_RES;
			if (hit_q) res_d.frame = OutFrW'(hit_f_q);
		end else if (hit_q) begin
			res_d.status = (req_q.mode == MODE_FETCH) ? ST_HIT : ST_CREATED;
			res_d.frame = OutFrW'(hit_f_q);
		end else if (used_q != CntW'(Frames) || vic_q) begin
			res_d.status = (req_q.mode == MODE_FETCH) ? ST_LOADED : ST_CREATED;
			res_d.read_needed = (req_q.mode == MODE_FETCH);
			if (used_q != CntW'(Frames)) begin
				res_d.frame = OutFrW'(used_q[FrW-1:0]);
			end else begin
				res_d.frame = OutFrW'(vic_f_q);
				if (dirty_q[vic_f_q]) begin
					res_d.writeback_needed = 1'b1;
					res_d.write_page = page_q[vic_f_q];
				end
			end
		end else begin
			res_d.status = ST_NO_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			used_q <= '0;
			ov_q <= 1'b0;
			for (int k = 0; k < Frames; k++) begin
				pin_q[k] <= '0;
				dirty_q[k] <= 1'b0;
			end
		end else begin
			st_q <= st_d;
			if (emit_ok || fl_word || fl_none) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (emit_ok) begin
				if (req_q.mode == MODE_UNPIN) begin
					if (hit_q) begin
						if (req_q.mark_dirty) dirty_q[hit_f_q] <= 1'b1;
						if (pin_q[hit_f_q] != '0) pin_q[hit_f_q] <= pin_q[hit_f_q] - 1'b1;
					end
				end else if (hit_q) begin
					if (pin_q[hit_f_q] != '1) pin_q[hit_f_q] <= pin_q[hit_f_q] + 1'b1;
					if (req_q.mode == MODE_NEW) dirty_q[hit_f_q] <= 1'b1;
					for (int k = 0; k < Frames; k++)
						if (CntW'(k) < used_q && rank_q[k] < rank_q[hit_f_q])
							rank_q[k] <= rank_q[k] + 1'b1;
					rank_q[hit_f_q] <= '0;
				end else if (used_q != CntW'(Frames)) begin
					page_q[used_q[FrW-1:0]] <= req_q.page_id;
					pin_q[used_q[FrW-1:0]] <= PinW'(1);
					dirty_q[used_q[FrW-1:0]] <= (req_q.mode == MODE_NEW);
					for (int k = 0; k < Frames; k++)
						if (CntW'(k) < used_q) rank_q[k] <= rank_q[k] + 1'b1;
					rank_q[used_q[FrW-1:0]] <= '0;
					used_q <= used_q + 1'b1;
				end else if (vic_q) begin
					page_q[vic_f_q] <= req_q.page_id;
					pin_q[vic_f_q] <= PinW'(1);
					dirty_q[vic_f_q] <= (req_q.mode == MODE_NEW);
					for (int k = 0; k < Frames; k++)
						if (rank_q[k] < rank_q[vic_f_q]) rank_q[k] <= rank_q[k] + 1'b1;
					rank_q[vic_f_q] <= '0;
				end
			end
			if (fl_word) dirty_q[i] <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_take) begin
			req_q <= q_req;
			idx_q <= '0;
			hit_q <= 1'b0;
			vic_q <= 1'b0;
			any_q <= 1'b0;
		end
		if (go_scan) begin
			idx_q <= idx_q + 1'b1;
			if (!hit_q && page_q[i] == req_q.page_id) begin
				hit_q <= 1'b1;
				hit_f_q <= i;
			end
			if (pin_q[i] == '0 && (!vic_q || rank_q[i] > rank_q[vic_f_q])) begin
				vic_q <= 1'b1;
				vic_f_q <= i;
			end
		end
		if (fl_step && used_q != '0) idx_q <= idx_q + 1'b1;
		if (fl_word) any_q <= 1'b1;
		if (emit_ok || fl_word || fl_none) res_q <= res_d;
	end
endmodule
`default_nettype wire

/* hw/rtl/page_frame_manager_lru_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_manager_lru_top: buffer pool frame manager with LRU replacement
// Tracks page per frame, pin counts, dirty marks and recency ranks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request word per handshake (mode, page_id, mark_dirty).
//   m_axis: result words; fetch/unpin/new give one word, flush gives one
//   word per dirty used frame in frame order (or one "nothing" word);
//   tlast marks the final word of a request.
//   Fetch/unpin/new are paced by the one-frame-per-cycle scan of the frame
//   table, then pass through a decide and an emit state. Flush steps through
//   the used frames in order, pausing while a result waits in the output register.
//   The back end runs one request at a time and takes the next one only
//   when it is back in idle.
//   A two-word input queue decouples intake from execution, and the output
//   register lets results wait while the queue keeps filling.
//   A stalled m_axis holds the result and pauses the back end.
//   Reset empties the pool: no frame used, all pins and dirty marks zero.
// ----------------------------------------------------------------------------
module page_frame_manager_lru_top import pfm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // mode[1:0], page_id[32:2], mark_dirty[33]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // status, frame, writeback_needed,
	                                        // write_page, read_needed
	output logic             m_axis_tlast
);
	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_take;

	assign in_req.mode = mode_t'(s_axis_tdata[1:0]);
	assign in_req.page_id = s_axis_tdata[32:2];
	assign in_req.mark_dirty = s_axis_tdata[33];

	pfm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_take(q_take), .q_req(q_req)
	);

	pfm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_take(q_take), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	// packed low to high: status 3, frame 4, wb 1, write_page 31, read 1
	assign m_axis_tdata = {res.read_needed, res.write_page, res.writeback_needed,
		res.frame, res.status};
	assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

/* bench/tb_page_frame_manager_lru_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_manager_lru_top: self-checking bench of the LRU frame manager
// Drives request words with random gaps and stalls the result side at random.
// A bench-side copy of the frame table predicts every result word, and each
// word that leaves the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_page_frame_manager_lru_top;
	import pfm_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int PoolSize = 24;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // mode[1:0], page_id[32:2], mark_dirty[33]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // status[2:0], frame[6:3], writeback_needed[7],
	                            // write_page[38:8], read_needed[39]
	logic        m_axis_tlast;

	page_frame_manager_lru_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// bench copy of the frame table
	logic [PageW-1:0] tbl_page [Frames];
	logic [PinW-1:0]  tbl_pins [Frames];
	logic             tbl_dirty[Frames];
	int               tbl_rank [Frames];
	int               tbl_used;

	res_t             pending_words[$];
	logic [PageW-1:0] page_pool[PoolSize];
	int               errors;
	int               cycles = 0;
	bit               calm;      // no gaps on either side while set
	int               hold_req;  // long receiver stall, in cycles

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random tready, plus a long hold when asked
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			g = gap_len();
			if (g > 0) begin
				m_axis_tready = 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// make frame f the most recent, ranks stay a permutation
	function automatic void make_recent(int f);
		int old;
		old = tbl_rank[f];
		for (int i = 0; i < tbl_used; i++)
			if (tbl_rank[i] < old)
				tbl_rank[i]++;
		tbl_rank[f] = 0;
	endfunction

	function automatic int lookup(logic [PageW-1:0] pid);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_page[i] == pid)
				return i;
		return -1;
	endfunction

	function automatic res_t word_of(status_t st, int f, logic wb, logic [PageW-1:0] wp,
			logic rd, logic lst);
		res_t w;
		w.status = st;
		w.frame = f[OutFrW-1:0];
		w.writeback_needed = wb;
		w.write_page = wp;
		w.read_needed = rd;
		w.last = lst;
		return w;
	endfunction

	// predicts the result words of one accepted request
	function automatic void predict_request(mode_t md, logic [PageW-1:0] pid, logic mk);
		int f;
		int n;
		logic wb;
		logic [PageW-1:0] wp;
		case (md)
			MODE_FETCH, MODE_NEW: begin
				f = lookup(pid);
				if (f >= 0) begin
					if (tbl_pins[f] != 8'hFF)
						tbl_pins[f]++;
					if (md == MODE_NEW)
						tbl_dirty[f] = 1'b1;
					make_recent(f);
					pending_words.push_back(word_of(md == MODE_FETCH ? ST_HIT : ST_CREATED,
						f, 1'b0, '0, 1'b0, 1'b1));
					return;
				end
				wb = 1'b0;
				wp = '0;
				if (tbl_used < Frames) begin
					f = tbl_used;
					tbl_rank[f] = tbl_used;
					tbl_used++;
				end else begin
					// victim: least recent unpinned frame
					f = -1;
					for (int i = 0; i < Frames; i++)
						if (tbl_pins[i] == 0 && (f < 0 || tbl_rank[i] > tbl_rank[f]))
							f = i;
					if (f >= 0 && tbl_dirty[f]) begin
						wb = 1'b1;
						wp = tbl_page[f];
					end
				end
				if (f < 0) begin
					pending_words.push_back(word_of(ST_NO_FRAME, 0, 1'b0, '0, 1'b0, 1'b1));
					return;
				end
				tbl_page[f] = pid;
				tbl_pins[f] = 1;
				tbl_dirty[f] = (md == MODE_NEW);
				make_recent(f);
				pending_words.push_back(word_of(md == MODE_FETCH ? ST_LOADED : ST_CREATED,
					f, wb, wp, md == MODE_FETCH, 1'b1));
			end
			MODE_UNPIN: begin
				f = lookup(pid);
				if (f < 0) begin
					pending_words.push_back(word_of(ST_NOT_RES, 0, 1'b0, '0, 1'b0, 1'b1));
					return;
				end
				if (mk)
					tbl_dirty[f] = 1'b1;
				if (tbl_pins[f] != 0)
					tbl_pins[f]--;
				pending_words.push_back(word_of(ST_UNPINNED, f, 1'b0, '0, 1'b0, 1'b1));
			end
			default: begin
				n = 0;
				for (int i = 0; i < tbl_used; i++) begin
					if (tbl_dirty[i]) begin
						pending_words.push_back(word_of(ST_FLUSHED, i, 1'b1, tbl_page[i],
							1'b0, 1'b0));
						tbl_dirty[i] = 1'b0;
						n++;
					end
				end
				if (n == 0)
					pending_words.push_back(word_of(ST_NOTHING, 0, 1'b0, '0, 1'b0, 1'b1));
				else
					pending_words[$].last = 1'b1;
			end
		endcase
	endfunction

	// sends one request word; valid stays high afterwards for back-to-back words
	task automatic send_request(mode_t md, logic [PageW-1:0] pid, logic mk);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata = {8'($urandom), $urandom};  // garbage while idle
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, mk, pid, md};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(md, pid, mk);
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = status_t'(m_axis_tdata[2:0]);
			got.frame = m_axis_tdata[6:3];
			got.writeback_needed = m_axis_tdata[7];
			got.write_page = m_axis_tdata[38:8];
			got.read_needed = m_axis_tdata[39];
			got.last = m_axis_tlast;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (got.status != want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.frame != want.frame) begin
					$display("%0t: frame exp %0d got %0d", $time, want.frame, got.frame);
					errors++;
				end
				if (got.writeback_needed != want.writeback_needed) begin
					$display("%0t: writeback_needed exp %b got %b", $time,
						want.writeback_needed, got.writeback_needed);
					errors++;
				end
				if (got.write_page != want.write_page) begin
					$display("%0t: write_page exp %h got %h", $time, want.write_page,
						got.write_page);
					errors++;
				end
				if (got.read_needed != want.read_needed) begin
					$display("%0t: read_needed exp %b got %b", $time, want.read_needed,
						got.read_needed);
					errors++;
				end
				if (got.last != want.last) begin
					$display("%0t: last exp %b got %b", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	// empty flush, extreme ids, hits, new on resident page, unpin corners,
	// filling all frames and running out of unpinned ones
	task automatic test_directed();
		send_request(MODE_FLUSH, '0, 1'b1);
		send_request(MODE_FETCH, page_pool[0], 1'b1);
		send_request(MODE_FETCH, page_pool[1], 1'b0);
		send_request(MODE_FETCH, page_pool[1], 1'b0);
		send_request(MODE_NEW, page_pool[2], 1'b0);
		send_request(MODE_NEW, page_pool[1], 1'b0);
		send_request(MODE_UNPIN, page_pool[3], 1'b1);
		send_request(MODE_UNPIN, page_pool[2], 1'b1);
		send_request(MODE_UNPIN, page_pool[2], 1'b0);
		send_request(MODE_FLUSH, '0, 1'b0);
		// the last fetch of the loop evicts the frame of pool[2], the only unpinned one
		for (int i = 3; i < 17; i++)
			send_request(MODE_FETCH, page_pool[i], 1'b0);
		send_request(MODE_FETCH, page_pool[17], 1'b0);
		send_request(MODE_FETCH, page_pool[18], 1'b0);
		send_request(MODE_UNPIN, page_pool[5], 1'b1);
		send_request(MODE_FETCH, page_pool[19], 1'b0);
	endtask

	// pin count saturates at its top and then walks down by one
	task automatic test_pin_saturation();
		calm = 1'b1;
		for (int i = 0; i < 258; i++)
			send_request(MODE_FETCH, page_pool[0], $urandom_range(0, 1));
		calm = 1'b0;
		repeat (3) send_request(MODE_UNPIN, page_pool[0], 1'b0);
	endtask

	// mixed random traffic over a small page pool, with one long output stall
	task automatic test_random_traffic();
		int r;
		logic [PageW-1:0] pid;
		for (int n = 0; n < 140; n++) begin
			if (n == 40)
				hold_req = 300;
			calm = (n >= 90 && n < 110);
			r = $urandom_range(0, 99);
			pid = ($urandom_range(0, 9) == 0) ? PageW'($urandom) :
				page_pool[$urandom_range(0, PoolSize - 1)];
			if (r < 38)
				send_request(MODE_FETCH, pid, $urandom_range(0, 1));
			else if (r < 72)
				send_request(MODE_UNPIN, pid, $urandom_range(0, 1));
			else if (r < 92)
				send_request(MODE_NEW, pid, $urandom_range(0, 1));
			else
				send_request(MODE_FLUSH, pid, $urandom_range(0, 1));
		end
		calm = 1'b0;
	endtask

	initial begin
		errors = 0;
		calm = 1'b0;
		hold_req = 0;
		tbl_used = 0;
		for (int i = 0; i < Frames; i++) begin
			tbl_page[i] = '0;
			tbl_pins[i] = '0;
			tbl_dirty[i] = 1'b0;
			tbl_rank[i] = 0;
		end
		page_pool[0] = '0;
		page_pool[1] = '1;
		for (int i = 2; i < PoolSize; i++)
			page_pool[i] = PageW'($urandom);
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_pin_saturation();
		test_random_traffic();

		s_axis_tvalid = 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/pfm_pkg.sv
hw/rtl/pfm_front.sv
hw/rtl/pfm_back.sv
hw/rtl/page_frame_manager_lru_top.sv
bench/tb_page_frame_manager_lru_top.sv
